/* sv/rvdec_pkg.sv */
// rvdec_pkg: shared types and opcode constants of the rv32imfd instruction decoder
`timescale 1ns / 1ps

package rvdec_pkg;

    // major opcodes, bits 6:0 of the instruction word
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_JAL      = 7'h6F;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_OP       = 7'b0110011;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;
    localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
    localparam logic [6:0] OPC_STORE_FP = 7'h27;
    localparam logic [6:0] OPC_MADD     = 7'h43;
    localparam logic [6:0] OPC_MSUB     = 7'h47;
    localparam logic [6:0] OPC_NMSUB    = 7'h4B;
    localparam logic [6:0] OPC_NMADD    = 7'h4F;
    localparam logic [6:0] OPC_OP_FP    = 7'b1010011;

    // funct7 codes of the OP-FP opcode
    localparam logic [6:0] F7_FADD_S   = 7'h00;
    localparam logic [6:0] F7_FADD_D   = 7'h01;
    localparam logic [6:0] F7_FSUB_S   = 7'h04;
    localparam logic [6:0] F7_FSUB_D   = 7'h05;
    localparam logic [6:0] F7_FMUL_S   = 7'h08;
    localparam logic [6:0] F7_FMUL_D   = 7'h09;
    localparam logic [6:0] F7_FDIV_S   = 7'h0C;
    localparam logic [6:0] F7_FDIV_D   = 7'h0D;
    localparam logic [6:0] F7_FSGNJ_S  = 7'h10;
    localparam logic [6:0] F7_FSGNJ_D  = 7'h11;
    localparam logic [6:0] F7_FMINX_S  = 7'h14;
    localparam logic [6:0] F7_FMINX_D  = 7'h15;
    localparam logic [6:0] F7_FCVT_SD  = 7'h20;
    localparam logic [6:0] F7_FCVT_DS  = 7'h21;
    localparam logic [6:0] F7_FSQRT_S  = 7'h2C;
    localparam logic [6:0] F7_FSQRT_D  = 7'h2D;
    localparam logic [6:0] F7_FCMP_S   = 7'h50;
    localparam logic [6:0] F7_FCMP_D   = 7'h51;
    localparam logic [6:0] F7_FCVT_WS  = 7'h60;
    localparam logic [6:0] F7_FCVT_WD  = 7'h61;
    localparam logic [6:0] F7_FCVT_SW  = 7'h68;
    localparam logic [6:0] F7_FCVT_DW  = 7'h69;
    localparam logic [6:0] F7_FMV_XW   = 7'h70;
    localparam logic [6:0] F7_FCLASS_D = 7'h71;
    localparam logic [6:0] F7_FMV_WX   = 7'h78;

    // dense mnemonic codes, zero means no match
    typedef enum logic [6:0] {
        INST_NONE = 7'd0,
        INST_LUI, INST_AUIPC, INST_JAL, INST_JALR,
        INST_BEQ, INST_BNE, INST_BLT, INST_BGE, INST_BLTU, INST_BGEU,
        INST_LB, INST_LH, INST_LW, INST_LBU, INST_LHU,
        INST_SB, INST_SH, INST_SW,
        INST_ADDI, INST_SLTI, INST_SLTIU, INST_XORI, INST_ORI, INST_ANDI,
        INST_SLLI, INST_SRLI, INST_SRAI,
        INST_ADD, INST_SUB, INST_SLL, INST_SLT, INST_SLTU, INST_XOR, INST_SRL,
        INST_SRA, INST_OR, INST_AND,
        INST_ECALL, INST_EBREAK, INST_CSRRW, INST_CSRRS, INST_CSRRC,
        INST_CSRRWI, INST_CSRRSI, INST_CSRRCI,
        INST_MUL, INST_MULH, INST_MULHSU, INST_MULHU, INST_DIV, INST_DIVU,
        INST_REM, INST_REMU,
        INST_FLW, INST_FSW, INST_FMADD_S, INST_FMSUB_S, INST_FNMSUB_S, INST_FNMADD_S,
        INST_FADD_S, INST_FSUB_S, INST_FMUL_S, INST_FDIV_S, INST_FSQRT_S,
        INST_FSGNJ_S, INST_FSGNJN_S, INST_FSGNJX_S, INST_FMIN_S, INST_FMAX_S,
        INST_FCVT_W_S, INST_FCVT_WU_S, INST_FMV_X_W, INST_FEQ_S, INST_FLT_S,
        INST_FLE_S, INST_FCLASS_S, INST_FCVT_S_W, INST_FCVT_S_WU, INST_FMV_W_X,
        INST_FLD, INST_FSD, INST_FMADD_D, INST_FMSUB_D, INST_FNMSUB_D, INST_FNMADD_D,
        INST_FADD_D, INST_FSUB_D, INST_FMUL_D, INST_FDIV_D, INST_FSQRT_D,
        INST_FSGNJ_D, INST_FSGNJN_D, INST_FSGNJX_D, INST_FMIN_D, INST_FMAX_D,
        INST_FCVT_S_D, INST_FCVT_D_S, INST_FEQ_D, INST_FLT_D, INST_FLE_D,
        INST_FCLASS_D, INST_FCVT_W_D, INST_FCVT_WU_D, INST_FCVT_D_W, INST_FCVT_D_WU
    } inst_type_t;

    typedef enum logic [2:0] {
        FMT_R  = 3'd0,
        FMT_I  = 3'd1,
        FMT_S  = 3'd2,
        FMT_B  = 3'd3,
        FMT_U  = 3'd4,
        FMT_J  = 3'd5,
        FMT_R4 = 3'd6
    } fmt_t;

    // one decoded instruction
    typedef struct packed {
        inst_type_t         inst_type;
        logic               illegal;
        fmt_t               format;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic [4:0]         rs3;
        logic [2:0]         round_mode;
        logic signed [31:0] immediate;
    } dec_result_t;

endpackage

/* sv/rvdec_classify.sv */
// rvdec_classify: maps an instruction word to its mnemonic code
`timescale 1ns / 1ps

module rvdec_classify (
    input  logic [31:0]            instruction,
    output rvdec_pkg::inst_type_t  inst_type
);

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       f2_nz;
    logic       r2_nz;

    assign opc   = instruction[6:0];
    assign f3    = instruction[14:12];
    assign f7    = instruction[31:25];
    assign f2_nz = |instruction[26:25];
    assign r2_nz = |instruction[24:20];

    always_comb begin
        inst_type = rvdec_pkg::INST_NONE;
        case (opc)
            rvdec_pkg::OPC_LUI:      inst_type = rvdec_pkg::INST_LUI;
            rvdec_pkg::OPC_AUIPC:    inst_type = rvdec_pkg::INST_AUIPC;
            rvdec_pkg::OPC_JAL:      inst_type = rvdec_pkg::INST_JAL;
            rvdec_pkg::OPC_JALR:     inst_type = rvdec_pkg::INST_JALR;
            rvdec_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0:    inst_type = rvdec_pkg::INST_BEQ;
                    3'd1:    inst_type = rvdec_pkg::INST_BNE;
                    3'd4:    inst_type = rvdec_pkg::INST_BLT;
                    3'd5:    inst_type = rvdec_pkg::INST_BGE;
                    3'd6:    inst_type = rvdec_pkg::INST_BLTU;
                    3'd7:    inst_type = rvdec_pkg::INST_BGEU;
                    default: inst_type = rvdec_pkg::INST_NONE;
                endcase
            end
            rvdec_pkg::OPC_LOAD: begin
                case (f3)
                    3'd0:    inst_type = rvdec_pkg::INST_LB;
                    3'd1:    inst_type = rvdec_pkg::INST_LH;
                    3'd2:    inst_type = rvdec_pkg::INST_LW;
                    3'd4:    inst_type = rvdec_pkg::INST_LBU;
                    3'd5:    inst_type = rvdec_pkg::INST_LHU;
                    default: inst_type = rvdec_pkg::INST_NONE;
                endcase
            end
            rvdec_pkg::OPC_STORE: begin
                case (f3)
                    3'd0:    inst_type = rvdec_pkg::INST_SB;
                    3'd1:    inst_type = rvdec_pkg::INST_SH;
                    3'd2:    inst_type = rvdec_pkg::INST_SW;
                    default: inst_type = rvdec_pkg::INST_NONE;
                endcase
            end
            rvdec_pkg::OPC_OP_IMM: begin
                case (f3)
                    3'd0:    inst_type = rvdec_pkg::INST_ADDI;
                    3'd1:    inst_type = rvdec_pkg::INST_SLLI;
                    3'd2:    inst_type = rvdec_pkg::INST_SLTI;
                    3'd3:    inst_type = rvdec_pkg::INST_SLTIU;
                    3'd4:    inst_type = rvdec_pkg::INST_XORI;
                    3'd5:    inst_type = (|f7) ? rvdec_pkg::INST_SRAI : rvdec_pkg::INST_SRLI;
                    3'd6:    inst_type = rvdec_pkg::INST_ORI;
                    default: inst_type = rvdec_pkg::INST_ANDI;
                endcase
            end
            rvdec_pkg::OPC_OP: begin
                if (f7[0]) begin
                    // multiply/divide extension
                    case (f3)
                        3'd0:    inst_type = rvdec_pkg::INST_MUL;
                        3'd1:    inst_type = rvdec_pkg::INST_MULH;
                        3'd2:    inst_type = rvdec_pkg::INST_MULHSU;
                        3'd3:    inst_type = rvdec_pkg::INST_MULHU;
                        3'd4:    inst_type = rvdec_pkg::INST_DIV;
                        3'd5:    inst_type = rvdec_pkg::INST_DIVU;
                        3'd6:    inst_type = rvdec_pkg::INST_REM;
                        default: inst_type = rvdec_pkg::INST_REMU;
                    endcase
                end else begin
                    case (f3)
                        3'd0:    inst_type = (|f7) ? rvdec_pkg::INST_SUB : rvdec_pkg::INST_ADD;
                        3'd1:    inst_type = rvdec_pkg::INST_SLL;
                        3'd2:    inst_type = rvdec_pkg::INST_SLT;
                        3'd3:    inst_type = rvdec_pkg::INST_SLTU;
                        3'd4:    inst_type = rvdec_pkg::INST_XOR;
                        3'd5:    inst_type = (|f7) ? rvdec_pkg::INST_SRA : rvdec_pkg::INST_SRL;
                        3'd6:    inst_type = rvdec_pkg::INST_OR;
                        default: inst_type = rvdec_pkg::INST_AND;
                    endcase
                end
            end
            // fence is treated as a plain add
            rvdec_pkg::OPC_MISC_MEM: inst_type = rvdec_pkg::INST_ADD;
            rvdec_pkg::OPC_SYSTEM: begin
                case (f3)
                    3'd0:    inst_type = (|instruction[31:20]) ? rvdec_pkg::INST_EBREAK
                                                               : rvdec_pkg::INST_ECALL;
                    3'd1:    inst_type = rvdec_pkg::INST_CSRRW;
                    3'd2:    inst_type = rvdec_pkg::INST_CSRRS;
                    3'd3:    inst_type = rvdec_pkg::INST_CSRRC;
                    3'd5:    inst_type = rvdec_pkg::INST_CSRRWI;
                    3'd6:    inst_type = rvdec_pkg::INST_CSRRSI;
                    3'd7:    inst_type = rvdec_pkg::INST_CSRRCI;
                    default: inst_type = rvdec_pkg::INST_NONE;
                endcase
            end
            rvdec_pkg::OPC_LOAD_FP:
                inst_type = f3[0] ? rvdec_pkg::INST_FLD : rvdec_pkg::INST_FLW;
            rvdec_pkg::OPC_STORE_FP:
                inst_type = f3[0] ? rvdec_pkg::INST_FSD : rvdec_pkg::INST_FSW;
            rvdec_pkg::OPC_MADD:
                inst_type = f2_nz ? rvdec_pkg::INST_FMADD_D : rvdec_pkg::INST_FMADD_S;
            rvdec_pkg::OPC_MSUB:
                inst_type = f2_nz ? rvdec_pkg::INST_FMSUB_D : rvdec_pkg::INST_FMSUB_S;
            rvdec_pkg::OPC_NMSUB:
                inst_type = f2_nz ? rvdec_pkg::INST_FNMSUB_D : rvdec_pkg::INST_FNMSUB_S;
            rvdec_pkg::OPC_NMADD:
                inst_type = f2_nz ? rvdec_pkg::INST_FNMADD_D : rvdec_pkg::INST_FNMADD_S;
            rvdec_pkg::OPC_OP_FP: begin
                case (f7)
                    rvdec_pkg::F7_FADD_S:  inst_type = rvdec_pkg::INST_FADD_S;
                    rvdec_pkg::F7_FADD_D:  inst_type = rvdec_pkg::INST_FADD_D;
                    rvdec_pkg::F7_FSUB_S:  inst_type = rvdec_pkg::INST_FSUB_S;
                    rvdec_pkg::F7_FSUB_D:  inst_type = rvdec_pkg::INST_FSUB_D;
                    rvdec_pkg::F7_FMUL_S:  inst_type = rvdec_pkg::INST_FMUL_S;
                    rvdec_pkg::F7_FMUL_D:  inst_type = rvdec_pkg::INST_FMUL_D;
                    rvdec_pkg::F7_FDIV_S:  inst_type = rvdec_pkg::INST_FDIV_S;
                    rvdec_pkg::F7_FDIV_D:  inst_type = rvdec_pkg::INST_FDIV_D;
                    rvdec_pkg::F7_FSGNJ_S: begin
                        case (f3)
                            3'd0:    inst_type = rvdec_pkg::INST_FSGNJ_S;
                            3'd1:    inst_type = rvdec_pkg::INST_FSGNJN_S;
                            3'd2:    inst_type = rvdec_pkg::INST_FSGNJX_S;
                            default: inst_type = rvdec_pkg::INST_NONE;
                        endcase
                    end
                    rvdec_pkg::F7_FSGNJ_D: begin
                        case (f3)
                            3'd0:    inst_type = rvdec_pkg::INST_FSGNJ_D;
                            3'd1:    inst_type = rvdec_pkg::INST_FSGNJN_D;
                            3'd2:    inst_type = rvdec_pkg::INST_FSGNJX_D;
                            default: inst_type = rvdec_pkg::INST_NONE;
                        endcase
                    end
                    rvdec_pkg::F7_FMINX_S:
                        inst_type = (|f3) ? rvdec_pkg::INST_FMAX_S : rvdec_pkg::INST_FMIN_S;
                    rvdec_pkg::F7_FMINX_D:
                        inst_type = (|f3) ? rvdec_pkg::INST_FMAX_D : rvdec_pkg::INST_FMIN_D;
                    rvdec_pkg::F7_FCVT_SD: inst_type = rvdec_pkg::INST_FCVT_S_D;
                    rvdec_pkg::F7_FCVT_DS: inst_type = rvdec_pkg::INST_FCVT_D_S;
                    rvdec_pkg::F7_FSQRT_S: inst_type = rvdec_pkg::INST_FSQRT_S;
                    rvdec_pkg::F7_FSQRT_D: inst_type = rvdec_pkg::INST_FSQRT_D;
                    rvdec_pkg::F7_FCMP_S: begin
                        case (f3)
                            3'd0:    inst_type = rvdec_pkg::INST_FLE_S;
                            3'd1:    inst_type = rvdec_pkg::INST_FLT_S;
                            3'd2:    inst_type = rvdec_pkg::INST_FEQ_S;
                            default: inst_type = rvdec_pkg::INST_NONE;
                        endcase
                    end
                    rvdec_pkg::F7_FCMP_D: begin
                        case (f3)
                            3'd0:    inst_type = rvdec_pkg::INST_FLE_D;
                            3'd1:    inst_type = rvdec_pkg::INST_FLT_D;
                            3'd2:    inst_type = rvdec_pkg::INST_FEQ_D;
                            default: inst_type = rvdec_pkg::INST_NONE;
                        endcase
                    end
                    rvdec_pkg::F7_FCVT_WS:
                        inst_type = r2_nz ? rvdec_pkg::INST_FCVT_WU_S : rvdec_pkg::INST_FCVT_W_S;
                    rvdec_pkg::F7_FCVT_WD:
                        inst_type = r2_nz ? rvdec_pkg::INST_FCVT_WU_D : rvdec_pkg::INST_FCVT_W_D;
                    rvdec_pkg::F7_FCVT_SW:
                        inst_type = r2_nz ? rvdec_pkg::INST_FCVT_S_WU : rvdec_pkg::INST_FCVT_S_W;
                    rvdec_pkg::F7_FCVT_DW:
                        inst_type = r2_nz ? rvdec_pkg::INST_FCVT_D_WU : rvdec_pkg::INST_FCVT_D_W;
                    rvdec_pkg::F7_FMV_XW:
                        inst_type = (|f3) ? rvdec_pkg::INST_FCLASS_S : rvdec_pkg::INST_FMV_X_W;
                    rvdec_pkg::F7_FCLASS_D: inst_type = rvdec_pkg::INST_FCLASS_D;
                    rvdec_pkg::F7_FMV_WX:   inst_type = rvdec_pkg::INST_FMV_W_X;
                    default:                inst_type = rvdec_pkg::INST_NONE;
                endcase
            end
            default: inst_type = rvdec_pkg::INST_NONE;
        endcase
    end

endmodule

/* sv/rvdec_fields.sv */
// rvdec_fields: format lookup, register fields and immediate extraction
`timescale 1ns / 1ps

module rvdec_fields (
    input  logic [31:0]             instruction,
    input  rvdec_pkg::inst_type_t   inst_type,
    output rvdec_pkg::dec_result_t  result
);

    rvdec_pkg::fmt_t fmt;

    always_comb begin
        if (inst_type == rvdec_pkg::INST_LUI || inst_type == rvdec_pkg::INST_AUIPC) begin
            fmt = rvdec_pkg::FMT_U;
        end else if (inst_type == rvdec_pkg::INST_JAL) begin
            fmt = rvdec_pkg::FMT_J;
        end else if (inst_type inside {rvdec_pkg::INST_JALR, rvdec_pkg::INST_FLW,
                                       rvdec_pkg::INST_FLD,
                                       [rvdec_pkg::INST_LB:rvdec_pkg::INST_LHU],
                                       [rvdec_pkg::INST_ADDI:rvdec_pkg::INST_SRAI],
                                       [rvdec_pkg::INST_ECALL:rvdec_pkg::INST_CSRRCI]}) begin
            fmt = rvdec_pkg::FMT_I;
        end else if (inst_type inside {[rvdec_pkg::INST_BEQ:rvdec_pkg::INST_BGEU]}) begin
            fmt = rvdec_pkg::FMT_B;
        end else if (inst_type inside {rvdec_pkg::INST_FSW, rvdec_pkg::INST_FSD,
                                       [rvdec_pkg::INST_SB:rvdec_pkg::INST_SW]}) begin
            fmt = rvdec_pkg::FMT_S;
        end else if (inst_type inside {[rvdec_pkg::INST_FMADD_S:rvdec_pkg::INST_FNMADD_S],
                                       [rvdec_pkg::INST_FMADD_D:rvdec_pkg::INST_FNMADD_D]}) begin
            fmt = rvdec_pkg::FMT_R4;
        end else begin
            fmt = rvdec_pkg::FMT_R;
        end
    end

    always_comb begin
        result            = '0;
        result.inst_type  = inst_type;
        result.illegal    = (inst_type == rvdec_pkg::INST_NONE);
        if (inst_type != rvdec_pkg::INST_NONE) begin
            result.format = fmt;
            case (fmt)
                rvdec_pkg::FMT_R: begin
                    result.rd         = instruction[11:7];
                    result.rs1        = instruction[19:15];
                    result.rs2        = instruction[24:20];
                    result.round_mode = instruction[14:12];
                end
                rvdec_pkg::FMT_I: begin
                    result.rd        = instruction[11:7];
                    result.rs1       = instruction[19:15];
                    result.immediate = {{20{instruction[31]}}, instruction[31:20]};
                end
                rvdec_pkg::FMT_S: begin
                    result.rs1       = instruction[19:15];
                    result.rs2       = instruction[24:20];
                    result.immediate = {{20{instruction[31]}}, instruction[31:25],
                                        instruction[11:7]};
                end
                rvdec_pkg::FMT_B: begin
                    result.rs1       = instruction[19:15];
                    result.rs2       = instruction[24:20];
                    result.immediate = {{19{instruction[31]}}, instruction[31], instruction[7],
                                        instruction[30:25], instruction[11:8], 1'b0};
                end
                rvdec_pkg::FMT_U: begin
                    result.rd        = instruction[11:7];
                    result.immediate = {instruction[31:12], 12'd0};
                end
                rvdec_pkg::FMT_J: begin
                    result.rd        = instruction[11:7];
                    result.immediate = {{11{instruction[31]}}, instruction[31],
                                        instruction[19:12], instruction[20],
                                        instruction[30:21], 1'b0};
                end
                default: begin
                    // fused multiply-add
                    result.rd         = instruction[11:7];
                    result.rs1        = instruction[19:15];
                    result.rs2        = instruction[24:20];
                    result.rs3        = instruction[31:27];
                    result.round_mode = instruction[14:12];
                end
            endcase
        end
    end

endmodule

/* sv/rv32imfd_instruction_decoder.sv */
// rv32imfd_instruction_decoder: stream wrapper with input and result registers
`timescale 1ns / 1ps

// Decodes one 32-bit RV32IMFD instruction word per transaction into a mnemonic
// code, the encoding format, the register fields, the rounding mode and the
// sign-extended immediate. An instruction is taken every clock cycle unless
// both registers are full and the output is stalled; each word is held in the
// input register, decoded by the combinational logic between the two
// registers and then held in the result register. A stalled result holds in
// the result register while the input register still takes a new word, and
// ready drops on the input side only when both registers are full and the
// output is stalled. Words that match no supported instruction come back with
// tuser (illegal) high and all of tdata zero; fields a format does not use
// read as zero.
module rv32imfd_instruction_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] instruction

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] inst_type, [9:7] format, [14:10] rd, [19:15] rs1, [24:20] rs2,
    // [29:25] rs3, [32:30] round_mode, [64:33] immediate, [71:65] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser    // [0] illegal
);

    // input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_word_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rvdec_pkg::dec_result_t out_result_reg;

    // decode path
    rvdec_pkg::inst_type_t  dec_type;
    rvdec_pkg::dec_result_t dec_result;

    logic in_accept;
    logic out_load;

    // result register frees up when empty or drained this cycle
    assign out_load      = !out_valid_reg || m_axis_tready;
    // input register frees up when empty or moving on to the result register
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_word_reg <= s_axis_tdata;
        end
        if (out_load && in_valid_reg) begin
            out_result_reg <= dec_result;
        end
    end

    // opcode and function bit classification
    rvdec_classify u_classify (
        .instruction (in_word_reg),
        .inst_type   (dec_type)
    );

    // format, register fields and immediate
    rvdec_fields u_fields (
        .instruction (in_word_reg),
        .inst_type   (dec_type),
        .result      (dec_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.illegal;
    assign m_axis_tdata  = {7'd0,
                            out_result_reg.immediate,
                            out_result_reg.round_mode,
                            out_result_reg.rs3,
                            out_result_reg.rs2,
                            out_result_reg.rs1,
                            out_result_reg.rd,
                            out_result_reg.format,
                            out_result_reg.inst_type};

    // an illegal word carries an all-zero payload
    a_illegal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 72'd0))
        else $error("illegal result with nonzero payload");

    // illegal flag matches a zero mnemonic code
    a_illegal_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[6:0] == 7'd0)))
        else $error("illegal flag disagrees with mnemonic code");

    // rs3 only comes with the fused multiply-add format
    a_rs3_r4: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[29:25] != 5'd0))
            |-> (m_axis_tdata[9:7] == rvdec_pkg::FMT_R4))
        else $error("rs3 set outside fused multiply-add format");

    // a held input word moves into a free result register on the next edge
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> out_valid_reg)
        else $error("decoded word lost between stages");

endmodule

/* verif/tb.sv */
// tb: self-checking stream testbench for the rv32imfd instruction decoder
`timescale 1ns / 1ps

module tb;
    import rvdec_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;     // input and result register plus margin
    localparam int STALL_LIMIT  = 1000;  // cycles with no transaction on either side
    localparam int MAX_REPORTS  = 10;

    // funct3 / funct7 codes of the integer opcodes that the package does not name
    localparam logic [2:0] F3_ADD_SUB     = 3'd0;
    localparam logic [2:0] F3_SHIFT_RIGHT = 3'd5;
    localparam logic [2:0] F3_PRIV        = 3'd0;
    localparam logic [6:0] F7_BASE        = 7'h00;
    localparam logic [6:0] F7_ALT         = 7'h20;
    localparam logic [6:0] F7_MULDIV      = 7'h01;

    // mnemonic lookup by funct3, none where the slot is unused or decoded separately
    localparam inst_type_t BRANCH_OPS [8] = '{INST_BEQ, INST_BNE, INST_NONE, INST_NONE,
                                              INST_BLT, INST_BGE, INST_BLTU, INST_BGEU};
    localparam inst_type_t LOAD_OPS [8]   = '{INST_LB, INST_LH, INST_LW, INST_NONE,
                                              INST_LBU, INST_LHU, INST_NONE, INST_NONE};
    localparam inst_type_t STORE_OPS [8]  = '{INST_SB, INST_SH, INST_SW, INST_NONE,
                                              INST_NONE, INST_NONE, INST_NONE, INST_NONE};
    localparam inst_type_t IMM_OPS [8]    = '{INST_ADDI, INST_SLLI, INST_SLTI, INST_SLTIU,
                                              INST_XORI, INST_NONE, INST_ORI, INST_ANDI};
    localparam inst_type_t REG_OPS [8]    = '{INST_NONE, INST_SLL, INST_SLT, INST_SLTU,
                                              INST_XOR, INST_NONE, INST_OR, INST_AND};
    localparam inst_type_t MULDIV_OPS [8] = '{INST_MUL, INST_MULH, INST_MULHSU, INST_MULHU,
                                              INST_DIV, INST_DIVU, INST_REM, INST_REMU};
    localparam inst_type_t SYSTEM_OPS [8] = '{INST_NONE, INST_CSRRW, INST_CSRRS, INST_CSRRC,
                                              INST_NONE, INST_CSRRWI, INST_CSRRSI,
                                              INST_CSRRCI};
    localparam inst_type_t SGNJ_S_OPS [8] = '{INST_FSGNJ_S, INST_FSGNJN_S, INST_FSGNJX_S,
                                              INST_NONE, INST_NONE, INST_NONE, INST_NONE,
                                              INST_NONE};
    localparam inst_type_t SGNJ_D_OPS [8] = '{INST_FSGNJ_D, INST_FSGNJN_D, INST_FSGNJX_D,
                                              INST_NONE, INST_NONE, INST_NONE, INST_NONE,
                                              INST_NONE};
    localparam inst_type_t FCMP_S_OPS [8] = '{INST_FLE_S, INST_FLT_S, INST_FEQ_S, INST_NONE,
                                              INST_NONE, INST_NONE, INST_NONE, INST_NONE};
    localparam inst_type_t FCMP_D_OPS [8] = '{INST_FLE_D, INST_FLT_D, INST_FEQ_D, INST_NONE,
                                              INST_NONE, INST_NONE, INST_NONE, INST_NONE};

    // opcode and funct7 pools that steer random words into real instructions
    localparam logic [6:0] KNOWN_OPCODES [18] = '{
        OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
        OPC_OP_IMM, OPC_OP, OPC_MISC_MEM, OPC_SYSTEM, OPC_LOAD_FP, OPC_STORE_FP,
        OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD, OPC_OP_FP};
    localparam logic [6:0] FP_FUNCT7S [25] = '{
        F7_FADD_S, F7_FADD_D, F7_FSUB_S, F7_FSUB_D, F7_FMUL_S, F7_FMUL_D, F7_FDIV_S,
        F7_FDIV_D, F7_FSGNJ_S, F7_FSGNJ_D, F7_FMINX_S, F7_FMINX_D, F7_FCVT_SD, F7_FCVT_DS,
        F7_FSQRT_S, F7_FSQRT_D, F7_FCMP_S, F7_FCMP_D, F7_FCVT_WS, F7_FCVT_WD, F7_FCVT_SW,
        F7_FCVT_DW, F7_FMV_XW, F7_FCLASS_D, F7_FMV_WX};

    // corner words: extremes of the immediates and every loose-decode corner
    localparam logic [31:0] DIRECTED_WORDS [27] = '{
        32'h0000_0000,   // all zero, no such opcode
        32'hFFFF_FFFF,   // all ones, no such opcode
        32'hFFFF_FFB7,   // lui, every upper bit set
        32'h0000_0017,   // auipc, zero immediate
        32'hFFFF_FFEF,   // jal, every immediate bit set, offset -2
        32'h7FF0_00E7,   // jalr, largest positive offset
        32'hFE20_FEE3,   // bgeu, negative offset
        32'h0000_2063,   // branch with unused funct3
        32'h0000_3003,   // load with unused funct3
        32'h8000_5283,   // lhu, most negative offset
        32'hFE11_2FA3,   // sw, negative offset
        32'h0000_3023,   // store with unused funct3
        32'h0230_D093,   // srai picked by a funct7 other than the usual one
        32'h0420_81B3,   // sub picked by funct7 2 rather than the usual one
        32'h0220_F1B3,   // remu
        32'h4020_D1B3,   // sra
        32'h0FF0_000F,   // fence, taken as add
        32'h0000_0073,   // ecall
        32'h8000_0073,   // ebreak through the top bit alone
        32'h0000_4073,   // system with unused funct3
        32'h0000_3007,   // fld through bit 12
        32'hFC00_0043,   // fmadd.d, fmt field 2, rs3 31
        32'h0821_F24F,   // fnmadd.s, rounding mode 7
        32'h2800_5053,   // fmax.s through a nonzero funct3
        32'hC040_0053,   // fcvt.wu.s through a nonzero rs2
        32'hE000_1053,   // fclass.s through a nonzero funct3
        32'h2200_3053};  // fsgnj.d with unused funct3

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] instruction
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [6:0] inst_type, [9:7] format, [14:10] rd, [19:15] rs1, [24:20] rs2,
    // [29:25] rs3, [32:30] round_mode, [64:33] immediate, [71:65] zero
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;        // [0] illegal

    dec_result_t pending_decodes [$];  // predicted decodes, oldest first
    dec_result_t want_dec;
    dec_result_t seen_dec;
    logic [6:0]  seen_pad;
    int          mismatch_count = 0;
    int          stuck_cycles = 0;
    bit          send_gaps = 1'b0;    // sender idles between words
    bit          take_stalls = 1'b0;  // receiver stalls between results

    rv32imfd_instruction_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // mnemonic of a word; only opcode and function bits matter, the rest is don't-care
    function automatic inst_type_t classify_word(input logic [31:0] w);
        inst_type_t kind;
        logic [2:0] f3;
        logic [6:0] f7;
        logic       wide;     // fused ops: nonzero fmt field means double
        logic       r2_set;   // fcvt: nonzero rs2 means the unsigned form
        f3     = w[14:12];
        f7     = w[31:25];
        wide   = |w[26:25];
        r2_set = |w[24:20];
        kind   = INST_NONE;
        case (w[6:0])
            OPC_LUI:      kind = INST_LUI;
            OPC_AUIPC:    kind = INST_AUIPC;
            OPC_JAL:      kind = INST_JAL;
            OPC_JALR:     kind = INST_JALR;
            OPC_BRANCH:   kind = BRANCH_OPS[f3];
            OPC_LOAD:     kind = LOAD_OPS[f3];
            OPC_STORE:    kind = STORE_OPS[f3];
            OPC_OP_IMM: begin
                if (f3 == F3_SHIFT_RIGHT)
                    kind = (f7 != F7_BASE) ? INST_SRAI : INST_SRLI;
                else
                    kind = IMM_OPS[f3];
            end
            OPC_OP: begin
                // low funct7 bit wins over everything else on this opcode
                if (f7[0])
                    kind = MULDIV_OPS[f3];
                else if (f3 == F3_ADD_SUB)
                    kind = (f7 != F7_BASE) ? INST_SUB : INST_ADD;
                else if (f3 == F3_SHIFT_RIGHT)
                    kind = (f7 != F7_BASE) ? INST_SRA : INST_SRL;
                else
                    kind = REG_OPS[f3];
            end
            OPC_MISC_MEM: kind = INST_ADD;
            OPC_SYSTEM: begin
                if (f3 == F3_PRIV)
                    kind = (|w[31:20]) ? INST_EBREAK : INST_ECALL;
                else
                    kind = SYSTEM_OPS[f3];
            end
            OPC_LOAD_FP:  kind = w[12] ? INST_FLD : INST_FLW;
            OPC_STORE_FP: kind = w[12] ? INST_FSD : INST_FSW;
            OPC_MADD:     kind = wide ? INST_FMADD_D : INST_FMADD_S;
            OPC_MSUB:     kind = wide ? INST_FMSUB_D : INST_FMSUB_S;
            OPC_NMSUB:    kind = wide ? INST_FNMSUB_D : INST_FNMSUB_S;
            OPC_NMADD:    kind = wide ? INST_FNMADD_D : INST_FNMADD_S;
            OPC_OP_FP: begin
                case (f7)
                    F7_FADD_S:   kind = INST_FADD_S;
                    F7_FADD_D:   kind = INST_FADD_D;
                    F7_FSUB_S:   kind = INST_FSUB_S;
                    F7_FSUB_D:   kind = INST_FSUB_D;
                    F7_FMUL_S:   kind = INST_FMUL_S;
                    F7_FMUL_D:   kind = INST_FMUL_D;
                    F7_FDIV_S:   kind = INST_FDIV_S;
                    F7_FDIV_D:   kind = INST_FDIV_D;
                    F7_FSGNJ_S:  kind = SGNJ_S_OPS[f3];
                    F7_FSGNJ_D:  kind = SGNJ_D_OPS[f3];
                    F7_FMINX_S:  kind = (|f3) ? INST_FMAX_S : INST_FMIN_S;
                    F7_FMINX_D:  kind = (|f3) ? INST_FMAX_D : INST_FMIN_D;
                    F7_FCVT_SD:  kind = INST_FCVT_S_D;
                    F7_FCVT_DS:  kind = INST_FCVT_D_S;
                    F7_FSQRT_S:  kind = INST_FSQRT_S;
                    F7_FSQRT_D:  kind = INST_FSQRT_D;
                    F7_FCMP_S:   kind = FCMP_S_OPS[f3];
                    F7_FCMP_D:   kind = FCMP_D_OPS[f3];
                    F7_FCVT_WS:  kind = r2_set ? INST_FCVT_WU_S : INST_FCVT_W_S;
                    F7_FCVT_WD:  kind = r2_set ? INST_FCVT_WU_D : INST_FCVT_W_D;
                    F7_FCVT_SW:  kind = r2_set ? INST_FCVT_S_WU : INST_FCVT_S_W;
                    F7_FCVT_DW:  kind = r2_set ? INST_FCVT_D_WU : INST_FCVT_D_W;
                    F7_FMV_XW:   kind = (|f3) ? INST_FCLASS_S : INST_FMV_X_W;
                    F7_FCLASS_D: kind = INST_FCLASS_D;
                    F7_FMV_WX:   kind = INST_FMV_W_X;
                    default:     kind = INST_NONE;
                endcase
            end
            default:      kind = INST_NONE;
        endcase
        return kind;
    endfunction

    function automatic fmt_t format_of(input inst_type_t t);
        if (t == INST_LUI || t == INST_AUIPC)
            return FMT_U;
        if (t == INST_JAL)
            return FMT_J;
        if (t >= INST_BEQ && t <= INST_BGEU)
            return FMT_B;
        if (t == INST_JALR || (t >= INST_LB && t <= INST_LHU) ||
            (t >= INST_ADDI && t <= INST_SRAI) || (t >= INST_ECALL && t <= INST_CSRRCI) ||
            t == INST_FLW || t == INST_FLD)
            return FMT_I;
        if ((t >= INST_SB && t <= INST_SW) || t == INST_FSW || t == INST_FSD)
            return FMT_S;
        if ((t >= INST_FMADD_S && t <= INST_FNMADD_S) ||
            (t >= INST_FMADD_D && t <= INST_FNMADD_D))
            return FMT_R4;
        return FMT_R;
    endfunction

    // full predicted decode of one word; unused fields stay zero
    function automatic dec_result_t decode_word(input logic [31:0] w);
        dec_result_t d;
        d = '0;
        d.inst_type = classify_word(w);
        if (d.inst_type == INST_NONE) begin
            d.illegal = 1'b1;
            return d;
        end
        d.format = format_of(d.inst_type);
        case (d.format)
            FMT_R, FMT_R4: begin
                d.rd         = w[11:7];
                d.rs1        = w[19:15];
                d.rs2        = w[24:20];
                d.round_mode = w[14:12];
                if (d.format == FMT_R4)
                    d.rs3 = w[31:27];
            end
            FMT_I: begin
                d.rd        = w[11:7];
                d.rs1       = w[19:15];
                d.immediate = {{20{w[31]}}, w[31:20]};
            end
            FMT_S: begin
                d.rs1       = w[19:15];
                d.rs2       = w[24:20];
                d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            FMT_B: begin
                d.rs1       = w[19:15];
                d.rs2       = w[24:20];
                d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            FMT_U: begin
                d.rd        = w[11:7];
                d.immediate = {w[31:12], 12'h000};
            end
            default: begin
                d.rd        = w[11:7];
                d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
        endcase
        return d;
    endfunction

    // mostly real instructions with random operands, one in ten pure noise
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) != 0) begin
            w[6:0] = KNOWN_OPCODES[$urandom_range(0, 17)];
            case (w[6:0])
                OPC_OP, OPC_OP_IMM: begin
                    case ($urandom_range(0, 3))
                        0:       w[31:25] = F7_BASE;
                        1:       w[31:25] = F7_ALT;
                        2:       w[31:25] = F7_MULDIV;
                        default: ;
                    endcase
                end
                OPC_SYSTEM: begin
                    if ($urandom_range(0, 1) == 0)
                        w[31:20] = '0;
                end
                OPC_OP_FP: begin
                    if ($urandom_range(0, 4) != 0)
                        w[31:25] = FP_FUNCT7S[$urandom_range(0, 24)];
                    if ($urandom_range(0, 1) == 0)
                        w[24:20] = '0;
                    if ($urandom_range(0, 2) == 0)
                        w[14:12] = '0;
                end
                default: ;
            endcase
        end
        return w;
    endfunction

    // scoreboard: predict on every accepted word, check every accepted result
    always @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready && aresetn)
            pending_decodes.push_back(decode_word(s_axis_tdata));
        if (m_axis_tvalid && m_axis_tready && aresetn) begin
            seen_dec.inst_type  = inst_type_t'(m_axis_tdata[6:0]);
            seen_dec.illegal    = m_axis_tuser;
            seen_dec.format     = fmt_t'(m_axis_tdata[9:7]);
            seen_dec.rd         = m_axis_tdata[14:10];
            seen_dec.rs1        = m_axis_tdata[19:15];
            seen_dec.rs2        = m_axis_tdata[24:20];
            seen_dec.rs3        = m_axis_tdata[29:25];
            seen_dec.round_mode = m_axis_tdata[32:30];
            seen_dec.immediate  = m_axis_tdata[64:33];
            seen_pad            = m_axis_tdata[71:65];
            if (pending_decodes.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: result with no instruction pending, tdata %h tuser %b",
                             $realtime, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want_dec = pending_decodes.pop_front();
                if (seen_dec.inst_type !== want_dec.inst_type ||
                    seen_dec.illegal !== want_dec.illegal ||
                    seen_dec.format !== want_dec.format ||
                    seen_dec.rd !== want_dec.rd ||
                    seen_dec.rs1 !== want_dec.rs1 ||
                    seen_dec.rs2 !== want_dec.rs2 ||
                    seen_dec.rs3 !== want_dec.rs3 ||
                    seen_dec.round_mode !== want_dec.round_mode ||
                    seen_dec.immediate !== want_dec.immediate ||
                    seen_pad !== 7'd0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: decode mismatch", $realtime);
                        $display("  expected type %0d ill %b fmt %0d rd %0d rs1 %0d rs2 %0d",
                                 want_dec.inst_type, want_dec.illegal, want_dec.format,
                                 want_dec.rd, want_dec.rs1, want_dec.rs2);
                        $display("           rs3 %0d rm %0d imm %h pad 0",
                                 want_dec.rs3, want_dec.round_mode, want_dec.immediate);
                        $display("  actual   type %0d ill %b fmt %0d rd %0d rs1 %0d rs2 %0d",
                                 seen_dec.inst_type, seen_dec.illegal, seen_dec.format,
                                 seen_dec.rd, seen_dec.rs1, seen_dec.rs2);
                        $display("           rs3 %0d rm %0d imm %h pad %h",
                                 seen_dec.rs3, seen_dec.round_mode, seen_dec.immediate,
                                 seen_pad);
                    end
                    mismatch_count++;
                end
            end
        end
        // progress monitor for the watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // result side: per result draw a stall, then take one transaction
    initial begin
        int unsigned stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = take_stalls ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            @(negedge aclk);
        end
    end

    // entered and left at a falling edge; valid stays high after the transaction
    task automatic push_word(input logic [31:0] w);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic test_directed_words();
        send_gaps   = 1'b0;
        take_stalls = 1'b0;
        foreach (DIRECTED_WORDS[i])
            push_word(DIRECTED_WORDS[i]);
    endtask

    task automatic test_random_with_gaps();
        send_gaps   = 1'b1;
        take_stalls = 1'b1;
        repeat (180) push_word(random_word());
    endtask

    // sender holds off until the decoder has handed back every result
    task automatic test_pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_decodes.size() != 0) @(negedge aclk);
        repeat (20) push_word(random_word());
    endtask

    task automatic test_back_to_back();
        send_gaps   = 1'b0;
        take_stalls = 1'b0;
        repeat (100) push_word(random_word());
    endtask

    // full input rate against a stalling receiver fills both registers
    task automatic test_output_backpressure();
        send_gaps   = 1'b0;
        take_stalls = 1'b1;
        repeat (100) push_word(random_word());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_words();
        test_random_with_gaps();
        test_pause_until_drained();
        test_back_to_back();
        test_output_backpressure();

        // drain: no more words, wait for the last results plus pipeline margin
        s_axis_tvalid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_decodes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog: too long without any transaction means the handshake hung
    initial begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
